>>> design/psu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the PNG scanline unfilter unit.
// No dependencies.
package psu_pkg;

  // Row filter codes as carried by the filter-type byte
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  // Largest legal filter-type byte
  localparam logic [7:0] FILT_MAX_CODE = 8'd4;

  // Configuration register indexes
  localparam logic REG_ROW_BYTES = 1'b0;
  localparam logic REG_BPP       = 1'b1;

  localparam int unsigned CFG_WIDTH = 15;
  localparam int unsigned BPP_WIDTH = 3;
  localparam logic [BPP_WIDTH-1:0] BPP_MAX = 3'd4;

endpackage

>>> design/png_scanline_unfilter_unit.sv
`timescale 1ns / 1ps
// PNG scanline unfilter: rebuilds pixel bytes from the inflated filtered stream.
// Depends on psu_pkg, psu_ram, psu_predict.
//
// Input channel (in_valid/in_ready): one stream byte per request, either a row's
// filter-type byte or a filtered pixel byte; image_start marks the first byte of
// an image, which is taken as the first row's filter byte.
// Output channel (out_valid/out_ready): one reconstructed byte per pixel byte, with
// row_end on the last byte of each row. A filter type above 4 gives one result with
// bad_filter set, after which bytes are dropped until the next image_start.
// Filter bytes and dropped bytes give no result.
// Throughput: one byte per cycle while out_ready is held high. The line buffer
// read is issued when a byte is accepted; reconstruction and the write-back happen
// when the work stage passes its request on, and a result goes through the work
// stage and then the output register.
// A stall on out_ready holds the output register and the work stage; the input
// still takes a byte while the work stage is free or moving.
// Reset (rst, synchronous) clears the control state and sets the row length and
// bytes_per_pixel to 1; the line buffer needs no clearing, since the first row
// of every image reads its up neighbors as zero.
// cfg_we writes cfg_data into the register selected by cfg_index.
module png_scanline_unfilter_unit #(
  parameter int MAX_ROW_BYTES = 16384
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [psu_pkg::CFG_WIDTH-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           image_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     pixel_byte,
  output logic                           row_end,
  output logic                           bad_filter
);

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int RW = AW + 1;
  localparam int CW = (RW > psu_pkg::CFG_WIDTH) ? RW : psu_pkg::CFG_WIDTH;

  // Configuration
  logic [psu_pkg::CFG_WIDTH-1:0] row_len;
  logic [psu_pkg::BPP_WIDTH-1:0] bytes_per_pixel;
  logic [RW-1:0]                 eff_rb;
  logic [1:0]                    left_sel;

  // Row control
  logic           awaiting_filter;
  logic           on_first_row;
  logic           error_hold;
  logic [AW-1:0]  column;
  psu_pkg::filt_t row_filter;
  logic           awaiting_filter_next;
  logic           on_first_row_next;
  logic           error_hold_next;
  logic [AW-1:0]  column_next;
  psu_pkg::filt_t row_filter_next;
  logic           take_pixel;
  logic           take_bad;
  logic           row_last;
  logic [RW-1:0]  col_plus;

  // Work stage
  logic           s1_valid;
  logic           s1_bad;
  logic [7:0]     s1_byte;
  logic [AW-1:0]  s1_col;
  logic           s1_first_row;
  logic           s1_last;
  psu_pkg::filt_t s1_filter;
  logic           s1_fire;
  logic           in_fire;

  logic [31:0] left_bytes;
  logic [31:0] upleft_bytes;
  logic [31:0] left_eff;
  logic [31:0] upleft_eff;
  logic [7:0]  left;
  logic [7:0]  upleft;
  logic [7:0]  up;
  logic [7:0]  ram_rdata;
  logic [7:0]  value;
  logic        ram_re;
  logic        ram_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_len         <= psu_pkg::CFG_WIDTH'(1);
      bytes_per_pixel <= psu_pkg::BPP_WIDTH'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        psu_pkg::REG_ROW_BYTES: row_len <= cfg_data;
        psu_pkg::REG_BPP:       bytes_per_pixel <= cfg_data[psu_pkg::BPP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Clamp row length to [1, MAX_ROW_BYTES] and pixel size to [1, 4]
  always_comb begin
    if (row_len == '0) begin
      eff_rb = RW'(1);
    end else if (CW'(row_len) > CW'(MAX_ROW_BYTES)) begin
      eff_rb = RW'(MAX_ROW_BYTES);
    end else begin
      eff_rb = RW'(row_len);
    end
    if (bytes_per_pixel == '0) begin
      left_sel = 2'd0;
    end else if (bytes_per_pixel > psu_pkg::BPP_MAX) begin
      left_sel = 2'd3;
    end else begin
      left_sel = 2'(bytes_per_pixel - psu_pkg::BPP_WIDTH'(1));
    end
  end

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign col_plus = {1'b0, column} + RW'(1);
  assign row_last = col_plus >= eff_rb;

  // Classify the incoming byte and advance row control
  always_comb begin
    awaiting_filter_next = awaiting_filter;
    on_first_row_next    = on_first_row;
    error_hold_next      = error_hold;
    column_next          = column;
    row_filter_next      = row_filter;
    take_pixel           = 1'b0;
    take_bad             = 1'b0;
    if (image_start) begin
      error_hold_next      = 1'b0;
      awaiting_filter_next = 1'b1;
      on_first_row_next    = 1'b1;
      column_next          = '0;
    end
    if (image_start || !error_hold) begin
      if (image_start || awaiting_filter) begin
        column_next = '0;
        if (data_byte > psu_pkg::FILT_MAX_CODE) begin
          error_hold_next = 1'b1;
          take_bad        = 1'b1;
        end else begin
          row_filter_next      = psu_pkg::filt_t'(data_byte[2:0]);
          awaiting_filter_next = 1'b0;
        end
      end else begin
        take_pixel = 1'b1;
        if (row_last) begin
          column_next          = '0;
          awaiting_filter_next = 1'b1;
          on_first_row_next    = 1'b0;
        end else begin
          column_next = col_plus[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_filter <= 1'b1;
      on_first_row    <= 1'b1;
      error_hold      <= 1'b0;
      column          <= '0;
      row_filter      <= psu_pkg::FILT_NONE;
    end else if (in_fire) begin
      awaiting_filter <= awaiting_filter_next;
      on_first_row    <= on_first_row_next;
      error_hold      <= error_hold_next;
      column          <= column_next;
      row_filter      <= row_filter_next;
    end
  end

  // Work stage: holds the request while the line buffer read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= take_pixel || take_bad;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_bad       <= take_bad;
      s1_byte      <= data_byte;
      s1_col       <= column;
      s1_first_row <= on_first_row;
      s1_last      <= row_last;
      s1_filter    <= row_filter;
    end
  end

  assign ram_re = in_fire && take_pixel;
  assign ram_we = s1_fire && !s1_bad;

  psu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col),
    .wdata (value),
    .re    (ram_re),
    .raddr (column),
    .rdata (ram_rdata)
  );

  // Left and upper-left history reads as zero at the row start
  always_comb begin
    left_eff   = (s1_col == '0) ? 32'd0 : left_bytes;
    upleft_eff = (s1_col == '0) ? 32'd0 : upleft_bytes;
    left       = left_eff[8*left_sel +: 8];
    upleft     = upleft_eff[8*left_sel +: 8];
    up         = s1_first_row ? 8'd0 : ram_rdata;
  end

  psu_predict u_predict (
    .filt      (s1_filter),
    .data_byte (s1_byte),
    .left      (left),
    .up        (up),
    .upleft    (upleft),
    .value     (value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_bytes   <= '0;
      upleft_bytes <= '0;
    end else if (ram_we) begin
      left_bytes   <= {left_eff[23:0], value};
      upleft_bytes <= {upleft_eff[23:0], up};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      pixel_byte <= s1_bad ? 8'd0 : value;
      row_end    <= !s1_bad && s1_last;
      bad_filter <= s1_bad;
    end
  end

`ifndef SYNTHESIS
  // A read and a write of the same line buffer entry never meet in one cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    ram_re && ram_we |-> column != s1_col)
    else $error("line buffer read and write hit the same entry");

  a_await_col_zero: assert property (@(posedge clk) disable iff (rst)
    awaiting_filter |-> column == '0)
    else $error("column not at zero while awaiting a filter byte");

  a_drop_no_work: assert property (@(posedge clk) disable iff (rst)
    in_fire && error_hold && !image_start |=> !s1_valid || $past(s1_valid && !s1_fire))
    else $error("dropped byte entered the work stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_col) && $stable(s1_byte))
    else $error("stalled work stage lost its request");

  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_filter |-> pixel_byte == 8'd0 && !row_end)
    else $error("error result carries pixel data");
`endif

endmodule

>>> design/psu_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/psu_predict.sv
`timescale 1ns / 1ps
// Byte reconstruction for the five PNG row filters (None, Sub, Up, Average, Paeth).
// Depends on psu_pkg.
module psu_predict (
  input  psu_pkg::filt_t filt,
  input  logic [7:0]     data_byte,
  input  logic [7:0]     left,
  input  logic [7:0]     up,
  input  logic [7:0]     upleft,
  output logic [7:0]     value
);

  logic [8:0]        avg_sum;
  logic signed [9:0] pa;
  logic signed [9:0] pb;
  logic signed [9:0] pc;
  logic [9:0]        abs_a;
  logic [9:0]        abs_b;
  logic [9:0]        abs_c;
  logic [7:0]        paeth;
  logic [7:0]        pred;

  // pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|
  always_comb begin
    avg_sum = {1'b0, left} + {1'b0, up};
    pa = $signed({2'b00, up}) - $signed({2'b00, upleft});
    pb = $signed({2'b00, left}) - $signed({2'b00, upleft});
    pc = pa + pb;
    abs_a = pa[9] ? 10'(-pa) : 10'(pa);
    abs_b = pb[9] ? 10'(-pb) : 10'(pb);
    abs_c = pc[9] ? 10'(-pc) : 10'(pc);
    if (abs_a <= abs_b && abs_a <= abs_c) begin
      paeth = left;
    end else if (abs_b <= abs_c) begin
      paeth = up;
    end else begin
      paeth = upleft;
    end
  end

  always_comb begin
    case (filt)
      psu_pkg::FILT_SUB:   pred = left;
      psu_pkg::FILT_UP:    pred = up;
      psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
      psu_pkg::FILT_PAETH: pred = paeth;
      default:             pred = 8'd0;
    endcase
    value = data_byte + pred;
  end

endmodule
